// ===== rtl/sbot_pkg.sv =====
package sbot_pkg;

    localparam int CoordW = 16;
    localparam int DiffW  = 17;
    localparam int ProdW  = 34;
    localparam int QuotW  = 34;
    localparam int WideW  = 35;

    typedef enum logic [1:0] {
        CMD_LOAD_VERTEX  = 2'd0,
        CMD_LOAD_SEGMENT = 2'd1,
        CMD_TEST         = 2'd2,
        CMD_NONE         = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LINE_LOW_Y  = 2'd0,
        LINE_HIGH_Y = 2'd1,
        LINE_LOW_X  = 2'd2,
        LINE_HIGH_X = 2'd3
    } line_sel_t;

    typedef struct packed {
        logic      capture;
        logic      write_vertex;
        logic      write_segment;
        logic      read_segment;
        logic      read_start;
        logic      read_end;
        logic      latch_start;
        logic      latch_end;
        logic      check_inside;
        logic      setup_line;
        line_sel_t line;
        logic      div_start;
        logic      div_step;
        logic      finish_line;
        logic      clear_hit;
    } sbot_cmd_t;

    typedef struct packed {
        logic      cmd_is_vertex;
        logic      cmd_is_segment;
        logic      cmd_is_test;
        logic      slot_ok;
        logic      line_crossed;
        logic      div_done;
        logic      hit;
    } sbot_status_t;

endpackage

// ===== rtl/segment_box_overlap_test_core.sv =====
// A load is written in the decode state, and the core then returns to idle.
// A test checks both ends against the box, then runs each of the four box
// lines, with a serial divide for a crossed line (one quotient bit a cycle).
// Throughput is one item at a time; the serial divider sets the test time.
// Reset is asynchronous and active low; the tables are not cleared by it.
module segment_box_overlap_test_core #(
    parameter int VERTEX_SLOTS  = 4096,
    parameter int SEGMENT_SLOTS = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [11:0]        slot,
    input  logic signed [15:0] px,
    input  logic signed [15:0] py,
    input  logic signed [15:0] qx,
    input  logic signed [15:0] qy,
    input  logic [11:0]        start_ref,
    input  logic [11:0]        end_ref,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit
);

    sbot_pkg::sbot_cmd_t    ctl;
    sbot_pkg::sbot_status_t sts;

    sbot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .ctl       (ctl),
        .sts       (sts)
    );

    sbot_datapath #(
        .VERTEX_SLOTS  (VERTEX_SLOTS),
        .SEGMENT_SLOTS (SEGMENT_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .slot      (slot),
        .px        (px),
        .py        (py),
        .qx        (qx),
        .qy        (qy),
        .start_ref (start_ref),
        .end_ref   (end_ref),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

// ===== rtl/sbot_datapath.sv =====
module sbot_datapath #(
    parameter int VERTEX_SLOTS  = 4096,
    parameter int SEGMENT_SLOTS = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              cmd,
    input  logic [11:0]             slot,
    input  logic signed [15:0]      px,
    input  logic signed [15:0]      py,
    input  logic signed [15:0]      qx,
    input  logic signed [15:0]      qy,
    input  logic [11:0]             start_ref,
    input  logic [11:0]             end_ref,
    input  sbot_pkg::sbot_cmd_t     ctl,
    output sbot_pkg::sbot_status_t  sts
);

    localparam int VaW = (VERTEX_SLOTS > 4096) ? 12 :
                         ((VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1);
    localparam int SaW = (SEGMENT_SLOTS > 4096) ? 12 :
                         ((SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1);
    localparam int CntW = $clog2(sbot_pkg::QuotW + 1);

    logic [31:0] vertex_mem [VERTEX_SLOTS];
    logic [23:0] segment_mem [SEGMENT_SLOTS];

    logic [1:0]         cmd_reg;
    logic [11:0]        slot_reg;
    logic signed [15:0] bx0_reg, by0_reg, bx1_reg, by1_reg;
    logic [11:0]        sref_reg, eref_reg;

    logic [23:0] seg_rd_reg;
    logic [31:0] vtx_rd_reg;
    logic        vtx_ok_reg;
    logic signed [15:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic        hit_reg;
    logic        crossed_reg;

    logic signed [16:0] a0_reg, lo_reg, hi_reg;
    logic signed [sbot_pkg::ProdW-1:0] num_reg;
    logic signed [sbot_pkg::DiffW-1:0] den_reg;
    logic neg_reg;
    logic [sbot_pkg::QuotW-1:0] rem_sh_reg;
    logic [sbot_pkg::QuotW-1:0] quo_reg;
    logic [sbot_pkg::WideW-1:0] part_reg;
    logic [sbot_pkg::DiffW-1:0] dmag_reg;
    logic [CntW-1:0] cnt_reg;

    logic [11:0] vref;
    logic signed [16:0] a0_w, b0_w, a1_w, b1_w, ln_w, lo_w, hi_w;
    logic signed [16:0] dl, da, db;
    logic [sbot_pkg::WideW-1:0] trial;
    logic signed [sbot_pkg::WideW-1:0] qs, cval;
    logic side0, side1;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            slot_reg <= slot;
            bx0_reg  <= px;
            by0_reg  <= py;
            bx1_reg  <= qx;
            by1_reg  <= qy;
            sref_reg <= start_ref;
            eref_reg <= end_ref;
        end
        if (ctl.write_vertex && sts.slot_ok)
            vertex_mem[slot_reg[VaW-1:0]] <= {by0_reg, bx0_reg};
        if (ctl.write_segment && sts.slot_ok)
            segment_mem[slot_reg[SaW-1:0]] <= {eref_reg, sref_reg};
        if (ctl.read_segment)
            seg_rd_reg <= segment_mem[slot_reg[SaW-1:0]];
        if (ctl.read_start || ctl.read_end)
        begin
            vtx_rd_reg <= vertex_mem[vref[VaW-1:0]];
            vtx_ok_reg <= (32'(vref) < 32'(VERTEX_SLOTS));
        end
        if (ctl.latch_start)
        begin
            sx_reg <= vtx_ok_reg ? vtx_rd_reg[15:0]  : '0;
            sy_reg <= vtx_ok_reg ? vtx_rd_reg[31:16] : '0;
        end
        if (ctl.latch_end)
        begin
            ex_reg <= vtx_ok_reg ? vtx_rd_reg[15:0]  : '0;
            ey_reg <= vtx_ok_reg ? vtx_rd_reg[31:16] : '0;
        end
    end

    assign vref = ctl.read_start ? seg_rd_reg[11:0] : seg_rd_reg[23:12];

    always_comb
    begin
        if (ctl.line == sbot_pkg::LINE_LOW_Y || ctl.line == sbot_pkg::LINE_HIGH_Y)
        begin
            a0_w = 17'(sx_reg);
            b0_w = 17'(sy_reg);
            a1_w = 17'(ex_reg);
            b1_w = 17'(ey_reg);
            ln_w = (ctl.line == sbot_pkg::LINE_LOW_Y) ? 17'(by0_reg) : 17'(by1_reg);
            lo_w = 17'(bx0_reg);
            hi_w = 17'(bx1_reg);
        end
        else
        begin
            a0_w = 17'(sy_reg);
            b0_w = 17'(sx_reg);
            a1_w = 17'(ey_reg);
            b1_w = 17'(ex_reg);
            ln_w = (ctl.line == sbot_pkg::LINE_LOW_X) ? 17'(bx0_reg) : 17'(bx1_reg);
            lo_w = 17'(by0_reg);
            hi_w = 17'(by1_reg);
        end
        dl = ln_w - b0_w;
        da = a1_w - a0_w;
        db = b1_w - b0_w;
        side0 = b0_w > ln_w;
        side1 = b1_w > ln_w;
    end

    assign trial = {part_reg[sbot_pkg::WideW-2:0], rem_sh_reg[sbot_pkg::QuotW-1]};
    assign qs = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign cval = qs + sbot_pkg::WideW'(a0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= 2'(sbot_pkg::CMD_NONE);
            hit_reg     <= 1'b0;
            crossed_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (ctl.capture)
                cmd_reg <= cmd;
            if (ctl.clear_hit)
                hit_reg <= 1'b0;
            if (ctl.check_inside)
            begin
                if ((sx_reg >= bx0_reg && sx_reg <= bx1_reg &&
                     sy_reg >= by0_reg && sy_reg <= by1_reg) ||
                    (ex_reg >= bx0_reg && ex_reg <= bx1_reg &&
                     ey_reg >= by0_reg && ey_reg <= by1_reg))
                    hit_reg <= 1'b1;
            end
            if (ctl.setup_line)
            begin
                crossed_reg <= (side0 != side1);
                num_reg     <= 34'(dl) * 34'(da);
                den_reg     <= db;
                a0_reg      <= a0_w;
                lo_reg      <= lo_w;
                hi_reg      <= hi_w;
            end
            if (ctl.div_start)
            begin
                neg_reg    <= num_reg[sbot_pkg::ProdW-1] ^ den_reg[sbot_pkg::DiffW-1];
                rem_sh_reg <= num_reg[sbot_pkg::ProdW-1] ? 34'(-num_reg) : 34'(num_reg);
                dmag_reg   <= den_reg[sbot_pkg::DiffW-1] ? 17'(-den_reg) : 17'(den_reg);
                part_reg   <= '0;
                quo_reg    <= '0;
                cnt_reg    <= CntW'(sbot_pkg::QuotW);
            end
            else if (ctl.div_step && cnt_reg != '0)
            begin
                if (trial >= sbot_pkg::WideW'(dmag_reg))
                begin
                    part_reg <= trial - sbot_pkg::WideW'(dmag_reg);
                    quo_reg  <= {quo_reg[sbot_pkg::QuotW-2:0], 1'b1};
                end
                else
                begin
                    part_reg <= trial;
                    quo_reg  <= {quo_reg[sbot_pkg::QuotW-2:0], 1'b0};
                end
                rem_sh_reg <= {rem_sh_reg[sbot_pkg::QuotW-2:0], 1'b0};
                cnt_reg    <= cnt_reg - 1'b1;
            end
            if (ctl.finish_line && crossed_reg &&
                cval >= sbot_pkg::WideW'(lo_reg) && cval <= sbot_pkg::WideW'(hi_reg))
                hit_reg <= 1'b1;
        end
    end

    always_comb
    begin
        sts.cmd_is_vertex  = (cmd_reg == 2'(sbot_pkg::CMD_LOAD_VERTEX));
        sts.cmd_is_segment = (cmd_reg == 2'(sbot_pkg::CMD_LOAD_SEGMENT));
        sts.cmd_is_test    = (cmd_reg == 2'(sbot_pkg::CMD_TEST));
        if (sts.cmd_is_vertex)
            sts.slot_ok = 32'(slot_reg) < 32'(VERTEX_SLOTS);
        else
            sts.slot_ok = 32'(slot_reg) < 32'(SEGMENT_SLOTS);
        sts.line_crossed = crossed_reg;
        sts.div_done     = (cnt_reg == '0);
        sts.hit          = hit_reg;
    end

endmodule

// ===== rtl/sbot_ctrl.sv =====
module sbot_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    hit,
    output sbot_pkg::sbot_cmd_t     ctl,
    input  sbot_pkg::sbot_status_t  sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_SEG,
        S_RD_START,
        S_LATCH_START,
        S_LATCH_END,
        S_INSIDE,
        S_SETUP,
        S_DIV_START,
        S_DIV,
        S_FINISH,
        S_OUT
    } state_t;

    state_t state_reg;
    sbot_pkg::line_sel_t line_reg;
    logic out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = sts.hit;

    always_comb
    begin
        ctl = '0;
        ctl.line = line_reg;
        unique case (state_reg)
            S_IDLE:        ctl.capture = in_valid;
            S_DECODE:
            begin
                ctl.write_vertex  = sts.cmd_is_vertex;
                ctl.write_segment = sts.cmd_is_segment;
                ctl.read_segment  = sts.cmd_is_test;
                ctl.clear_hit     = 1'b1;
            end
            S_RD_SEG:      ctl.read_start = 1'b1;
            S_RD_START:
            begin
                ctl.latch_start = 1'b1;
                ctl.read_end    = 1'b1;
            end
            S_LATCH_START: ctl.latch_end = 1'b1;
            S_LATCH_END:   ctl.check_inside = 1'b1;
            S_INSIDE:      ctl.setup_line = 1'b1;
            S_SETUP:       ctl.div_start = 1'b1;
            S_DIV_START:   ctl.div_step = 1'b1;
            S_DIV:         ctl.div_step = 1'b1;
            S_FINISH:      ctl.finish_line = 1'b1;
            S_OUT:         ctl.clear_hit = 1'b0;
            default:       ctl.clear_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            line_reg      <= sbot_pkg::LINE_LOW_Y;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_DECODE;
                S_DECODE:
                begin
                    line_reg <= sbot_pkg::LINE_LOW_Y;
                    if (sts.cmd_is_test && !sts.slot_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else if (sts.cmd_is_test)
                        state_reg <= S_RD_SEG;
                    else
                        state_reg <= S_IDLE;
                end
                S_RD_SEG:      state_reg <= S_RD_START;
                S_RD_START:    state_reg <= S_LATCH_START;
                S_LATCH_START: state_reg <= S_LATCH_END;
                S_LATCH_END:   state_reg <= S_INSIDE;
                S_INSIDE:      state_reg <= S_SETUP;
                S_SETUP:
                    state_reg <= sts.line_crossed ? S_DIV_START : S_FINISH;
                S_DIV_START:   state_reg <= S_DIV;
                S_DIV:
                    if (sts.div_done)
                        state_reg <= S_FINISH;
                S_FINISH:
                begin
                    if (line_reg == sbot_pkg::LINE_HIGH_X)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        line_reg  <= sbot_pkg::line_sel_t'(2'(line_reg) + 2'd1);
                        state_reg <= S_INSIDE;
                    end
                end
                S_OUT:
                begin
                    if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/sbot_checker.sv =====
module sbot_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic hit
);

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("Result beat dropped or changed while stalled.");

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Input taken while a result is pending.");

    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("Result raised while idle.");

    a_ready_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Ready stayed high after an accepted beat.");

endmodule

bind segment_box_overlap_test_core sbot_checker u_sbot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
);
